// ----- sv/assert_macros.svh -----
// Assertion shorthands shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("max pooling check failed");

// Clocked property that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("max pooling reset check failed");

`endif

// ----- sv/mp2d_pkg.sv -----
package mp2d_pkg;

    // Q8.8 sample
    localparam int DATA_W = 16;
    typedef logic signed [DATA_W-1:0] pixel_t;
    localparam pixel_t PIXEL_MIN = pixel_t'(16'h8000);

    // Register field widths
    localparam int HEIGHT_W = 7;
    localparam int WIDTH_W  = 7;
    localparam int CHAN_W   = 9;
    localparam int KERNEL_W = 3;
    localparam int STRIDE_W = 3;
    localparam int PHASE_W  = 2;

    // Largest stride the phase counters follow
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = 3'd4;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE      = 3'd4;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] RST_IN_HEIGHT   = 7'd8;
    localparam logic [WIDTH_W-1:0]  RST_IN_WIDTH    = 7'd8;
    localparam logic [CHAN_W-1:0]   RST_CHANNELS    = 9'd1;
    localparam logic [KERNEL_W-1:0] RST_KERNEL_SIZE = 3'd2;
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = 3'd2;

endpackage

// ----- sv/max_pooling_2d.sv -----
// Items that close no window are taken at 1 per cycle; one that closes a k x k window sends the
// sequencer through S_READ (k*k row store reads), S_LAST and S_EMIT, and its word shows on
// pooled_valid once S_EMIT finds the output register free, a waiting output word holding it
// there. No new item is taken until then; the single store read port feeds one comparator.
// Reset (rst_n, asynchronous, active low): registers 8, 8, 1, 2, 2, positions and phases zero.
// The row store is not cleared: every entry a window reads is written earlier in that channel.
module max_pooling_2d #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_KERNEL   = 4,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  mp2d_pkg::pixel_t                  pixel_value,
    output logic                              pooled_valid,
    input  logic                              pooled_ready,
    output mp2d_pkg::pixel_t                  pooled_value,
    output logic                              frame_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mp2d_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mp2d_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mp2d_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mp2d_pkg::*;

    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KW    = $clog2(MAX_KERNEL);
    localparam int KVW   = KW + 1;
    localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int M1    = (CLW > RW) ? CLW : RW;
    localparam int M2    = (CHW > CHAN_W) ? CHW : CHAN_W;
    localparam int CW    = ((M1 > M2) ? M1 : M2) + 2;

    localparam logic [CW-1:0] ONE_X = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [HEIGHT_W-1:0] in_height_reg;
    logic [WIDTH_W-1:0]  in_width_reg;
    logic [CHAN_W-1:0]   channels_reg;
    logic [KERNEL_W-1:0] kernel_size_reg;
    logic [STRIDE_W-1:0] stride_reg;

    // Position of the next word
    logic [CLW-1:0]     col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CHW-1:0]     chan_reg, chan_next;
    logic [PHASE_W-1:0] col_phase_reg, col_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [KW-1:0]      row_slot_reg, row_slot_next;

    // Window sweep
    logic [KW-1:0]  rd_slot_reg;
    logic [KW-1:0]  rd_off_reg;
    logic [CLW-1:0] base_col_reg;
    logic           rd_pend_reg;
    logic           last_reg;
    pixel_t         best_reg;
    pixel_t         rdata_reg;

    // Output register
    logic   pooled_valid_reg;
    pixel_t pooled_value_reg;
    logic   frame_last_reg;

    // Row store
    pixel_t store [DEPTH];

    logic [CW-1:0]       h_eff, w_eff, nc_eff, k_x, s_x, c_x, r_x, ch_x;
    logic [KVW-1:0]      k_eff;
    logic [STRIDE_W-1:0] s_eff;
    logic                accept, fire, win_last, cfg_write, cfg_hit, rd_off_wrap, rd_done;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [AW-1:0]       waddr, raddr;

    assign accept       = pixel_valid && pixel_ready;
    assign pixel_ready  = (state_reg == S_IDLE);
    assign pooled_valid = pooled_valid_reg;
    assign pooled_value = pooled_value_reg;
    assign frame_last   = frame_last_reg;
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign cfg_hit   = cfg_idx inside {REG_IN_HEIGHT, REG_IN_WIDTH, REG_CHANNELS,
                                       REG_KERNEL_SIZE, REG_STRIDE};

    // Clamp the sizes to what the counters and store hold
    always_comb
    begin
        if (in_height_reg == '0)
            h_eff = ONE_X;
        else if (CW'(in_height_reg) > CW'(MAX_HEIGHT))
            h_eff = CW'(MAX_HEIGHT);
        else
            h_eff = CW'(in_height_reg);

        if (in_width_reg == '0)
            w_eff = ONE_X;
        else if (CW'(in_width_reg) > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(in_width_reg);

        if (channels_reg == '0)
            nc_eff = ONE_X;
        else if (CW'(channels_reg) > CW'(MAX_CHANNELS))
            nc_eff = CW'(MAX_CHANNELS);
        else
            nc_eff = CW'(channels_reg);

        if (kernel_size_reg == '0)
            k_eff = KVW'(1);
        else if (CW'(kernel_size_reg) > CW'(MAX_KERNEL))
            k_eff = KVW'(MAX_KERNEL);
        else
            k_eff = KVW'(kernel_size_reg);

        if (stride_reg == '0)
            s_eff = STRIDE_W'(1);
        else if (stride_reg > STRIDE_MAX)
            s_eff = STRIDE_MAX;
        else
            s_eff = stride_reg;
    end

    assign k_x  = CW'(k_eff);
    assign s_x  = CW'(s_eff);
    assign c_x  = CW'(col_reg);
    assign r_x  = CW'(row_reg);
    assign ch_x = CW'(chan_reg);

    // Does this word close a window on the stride grid, and is it the frame's last window
    assign fire = (r_x + ONE_X >= k_x) && (c_x + ONE_X >= k_x)
               && (row_phase_reg == '0) && (col_phase_reg == '0)
               && (k_x <= h_eff) && (k_x <= w_eff);
    assign win_last = (ch_x + ONE_X == nc_eff) && (r_x + s_x >= h_eff) && (c_x + s_x >= w_eff);

    // Advance positions and phases
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        chan_next      = chan_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        row_slot_next  = row_slot_reg;
        if (c_x + ONE_X >= k_x)
            col_phase_next = (CW'(col_phase_reg) + ONE_X >= s_x) ? '0
                           : col_phase_reg + PHASE_W'(1);
        if (c_x + ONE_X < w_eff)
            col_next = col_reg + CLW'(1);
        else
        begin
            col_next       = '0;
            col_phase_next = '0;
            if (r_x + ONE_X >= k_x)
                row_phase_next = (CW'(row_phase_reg) + ONE_X >= s_x) ? '0
                               : row_phase_reg + PHASE_W'(1);
            row_slot_next = (CW'(row_slot_reg) + ONE_X >= k_x) ? '0
                          : row_slot_reg + KW'(1);
            if (r_x + ONE_X < h_eff)
                row_next = row_reg + RW'(1);
            else
            begin
                row_next       = '0;
                row_phase_next = '0;
                row_slot_next  = '0;
                chan_next      = (ch_x + ONE_X < nc_eff) ? chan_reg + CHW'(1) : '0;
            end
        end
    end

    // Store addresses: slot times row pitch plus column
    assign waddr = AW'(row_slot_reg) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign raddr = AW'(rd_slot_reg) * AW'(MAX_WIDTH) + AW'(base_col_reg + CLW'(rd_off_reg));

    assign rd_off_wrap = (CW'(rd_off_reg) + ONE_X == k_x);
    assign rd_done     = rd_off_wrap && (CW'(rd_slot_reg) + ONE_X == k_x);

    // Write the incoming word, read one window entry per cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            store[waddr] <= pixel_value;
        if (state_reg == S_READ)
            rdata_reg <= store[raddr];
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_IN_HEIGHT:   prdata = APB_DATA_W'(in_height_reg);
            REG_IN_WIDTH:    prdata = APB_DATA_W'(in_width_reg);
            REG_CHANNELS:    prdata = APB_DATA_W'(channels_reg);
            REG_KERNEL_SIZE: prdata = APB_DATA_W'(kernel_size_reg);
            REG_STRIDE:      prdata = APB_DATA_W'(stride_reg);
            default:         prdata = '0;
        endcase
    end

    // Sequencer, counters, comparator and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            in_height_reg    <= RST_IN_HEIGHT;
            in_width_reg     <= RST_IN_WIDTH;
            channels_reg     <= RST_CHANNELS;
            kernel_size_reg  <= RST_KERNEL_SIZE;
            stride_reg       <= RST_STRIDE;
            col_reg          <= '0;
            row_reg          <= '0;
            chan_reg         <= '0;
            col_phase_reg    <= '0;
            row_phase_reg    <= '0;
            row_slot_reg     <= '0;
            rd_slot_reg      <= '0;
            rd_off_reg       <= '0;
            base_col_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            last_reg         <= 1'b0;
            best_reg         <= PIXEL_MIN;
            pooled_valid_reg <= 1'b0;
            pooled_value_reg <= '0;
            frame_last_reg   <= 1'b0;
        end
        else
        begin
            // Drop the word once taken
            if (pooled_valid_reg && pooled_ready && (state_reg != S_EMIT))
                pooled_valid_reg <= 1'b0;

            // Fold the fetched entry into the running maximum
            rd_pend_reg <= (state_reg == S_READ);
            if (rd_pend_reg && (rdata_reg > best_reg))
                best_reg <= rdata_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && fire)
                    begin
                        state_reg    <= S_READ;
                        rd_slot_reg  <= '0;
                        rd_off_reg   <= '0;
                        base_col_reg <= CLW'(c_x + ONE_X - k_x);
                        last_reg     <= win_last;
                        best_reg     <= PIXEL_MIN;
                    end
                end
                S_READ:
                begin
                    if (rd_off_wrap)
                    begin
                        rd_off_reg  <= '0;
                        rd_slot_reg <= rd_slot_reg + KW'(1);
                    end
                    else
                        rd_off_reg <= rd_off_reg + KW'(1);
                    if (rd_done)
                        state_reg <= S_LAST;
                end
                S_LAST:
                    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    // Hold until the output register is free
                    if (!pooled_valid_reg || pooled_ready)
                    begin
                        pooled_valid_reg <= 1'b1;
                        pooled_value_reg <= best_reg;
                        frame_last_reg   <= last_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            // Register write: take the field and restart the frame; else advance on a word
            if (cfg_write && cfg_hit)
            begin
                case (cfg_idx)
                    REG_IN_HEIGHT:   in_height_reg   <= pwdata[HEIGHT_W-1:0];
                    REG_IN_WIDTH:    in_width_reg    <= pwdata[WIDTH_W-1:0];
                    REG_CHANNELS:    channels_reg    <= pwdata[CHAN_W-1:0];
                    REG_KERNEL_SIZE: kernel_size_reg <= pwdata[KERNEL_W-1:0];
                    REG_STRIDE:      stride_reg      <= pwdata[STRIDE_W-1:0];
                    default:         in_height_reg   <= in_height_reg;
                endcase
                col_reg       <= '0;
                row_reg       <= '0;
                chan_reg      <= '0;
                col_phase_reg <= '0;
                row_phase_reg <= '0;
                row_slot_reg  <= '0;
            end
            else if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                chan_reg      <= chan_next;
                col_phase_reg <= col_phase_next;
                row_phase_reg <= row_phase_next;
                row_slot_reg  <= row_slot_next;
            end
        end
    end

endmodule

// ----- sv/mp2d_checker.sv -----
`include "assert_macros.svh"

module mp2d_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input logic             pooled_valid,
    input logic             pooled_ready,
    input mp2d_pkg::pixel_t pooled_value,
    input logic             frame_last
);

    // A stalled word holds its payload
    `ASSERT_CLK(a_out_hold, pooled_valid && !pooled_ready |=>
        pooled_valid && $stable(pooled_value) && $stable(frame_last))

    // A result only appears after a busy spell
    `ASSERT_CLK(a_out_from_busy, $rose(pooled_valid) |-> $past(!pixel_ready))

    // The block only goes busy after taking a word
    `ASSERT_CLK(a_busy_after_accept, $fell(pixel_ready) |-> $past(pixel_valid))

    // Reset leaves the block ready and empty
    `ASSERT_CLK_ALWAYS(a_reset_state, !rst_n |=> !pooled_valid && pixel_ready)

endmodule

bind max_pooling_2d mp2d_checker u_mp2d_checker (.*);

// ----- sim/max_pooling_2d_test.sv -----
module max_pooling_2d_test;

    import mp2d_pkg::*;

    localparam int MAX_W  = 64;
    localparam int MAX_K  = 4;
    localparam int MAX_H  = 64;
    localparam int MAX_CH = 256;

    localparam int STORE_SLOTS   = MAX_K * MAX_W;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_WORDS  = 650;

    localparam pixel_t PIXEL_MAX = pixel_t'(16'h7FFF);

    // Two rows of an 8-wide map: all-minimum, maximum-holding, mixed-sign and near-zero windows
    localparam logic [255:0] EDGE_PIXELS = {
        16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
        16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFE, 16'hFFFF, 16'h8001, 16'h8000
    };

    typedef struct {
        pixel_t pooled;
        logic   last;
    } pool_word_t;

    typedef struct {
        int height;
        int width;
        int chans;
        int kernel;
        int stride;
    } pool_setting_t;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    pixel_t                pixel_value = '0;
    logic                  pooled_valid;
    logic                  pooled_ready = 1'b0;
    pixel_t                pooled_value;
    logic                  frame_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic [HEIGHT_W-1:0] cfg_height;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [CHAN_W-1:0]   cfg_channels;
    logic [KERNEL_W-1:0] cfg_kernel;
    logic [STRIDE_W-1:0] cfg_stride;
    pixel_t              pool_store [STORE_SLOTS];
    logic [5:0]          col_pos;
    logic [5:0]          row_pos;
    logic [7:0]          chan_pos;
    logic [PHASE_W-1:0]  row_ph;
    logic [PHASE_W-1:0]  col_ph;

    pool_word_t expected_pools [$];
    pixel_t     pixel_queue [$];

    int pixels_queued = 0;
    int pixels_taken = 0;
    int results_seen = 0;
    int frame_ends_seen = 0;
    int settings_run = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    int hold_left = 0;

    max_pooling_2d #(
        .MAX_WIDTH    (MAX_W),
        .MAX_KERNEL   (MAX_K),
        .MAX_HEIGHT   (MAX_H),
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .pooled_valid (pooled_valid),
        .pooled_ready (pooled_ready),
        .pooled_value (pooled_value),
        .frame_last   (frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = ~clk;
    end

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(7))
            0: return PIXEL_MIN;
            1: return PIXEL_MAX;
            2: return pixel_t'($urandom_range(8) - 4);
            default: return pixel_t'($urandom());
        endcase
    endfunction

    task automatic restart_frame();
        col_pos  = '0;
        row_pos  = '0;
        chan_pos = '0;
        row_ph   = '0;
        col_ph   = '0;
    endtask

    // Store one accepted pixel, queue the window maximum it completes, advance the position
    task automatic pool_pixel(input pixel_t px);
        int h, w, nc, k, s, r, c, ch, rr, cc, row_end, col_end;
        pool_word_t word;
        h  = clamp_to(cfg_height, 1, MAX_H);
        w  = clamp_to(cfg_width, 1, MAX_W);
        nc = clamp_to(cfg_channels, 1, MAX_CH);
        k  = clamp_to(cfg_kernel, 1, MAX_K);
        s  = clamp_to(cfg_stride, 1, STRIDE_MAX);
        r  = row_pos;
        c  = col_pos;
        ch = chan_pos;
        pool_store[(r % k) * MAX_W + c] = px;

        if (r + 1 >= k && c + 1 >= k && row_ph == 0 && col_ph == 0 && k <= h && k <= w)
        begin
            word.pooled = PIXEL_MIN;
            for (rr = r + 1 - k; rr <= r; rr++)
                for (cc = c + 1 - k; cc <= c; cc++)
                    if (pool_store[(rr % k) * MAX_W + cc] > word.pooled)
                        word.pooled = pool_store[(rr % k) * MAX_W + cc];
            row_end = (k - 1) + ((h - k) / s) * s;
            col_end = (k - 1) + ((w - k) / s) * s;
            word.last = (ch + 1 == nc && r == row_end && c == col_end);
            expected_pools.push_back(word);
        end

        // step the column phase once the window fits horizontally
        if (c + 1 >= k)
            col_ph = (col_ph + 1 >= s) ? '0 : col_ph + 1;
        if (c + 1 < w)
            col_pos = c + 1;
        else
        begin
            col_pos = '0;
            col_ph  = '0;
            if (r + 1 >= k)
                row_ph = (row_ph + 1 >= s) ? '0 : row_ph + 1;
            if (r + 1 < h)
                row_pos = r + 1;
            else
            begin
                row_pos  = '0;
                row_ph   = '0;
                chan_pos = (ch + 1 < nc) ? ch + 1 : 0;
            end
        end
    endtask

    // APB write: setup cycle, access cycle, register taken at the following edge
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IN_HEIGHT:   cfg_height   = value[HEIGHT_W-1:0];
            REG_IN_WIDTH:    cfg_width    = value[WIDTH_W-1:0];
            REG_CHANNELS:    cfg_channels = value[CHAN_W-1:0];
            REG_KERNEL_SIZE: cfg_kernel   = value[KERNEL_W-1:0];
            REG_STRIDE:      cfg_stride   = value[STRIDE_W-1:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic apply_setting(input pool_setting_t st);
        write_reg(REG_IN_HEIGHT, st.height);
        write_reg(REG_IN_WIDTH, st.width);
        write_reg(REG_CHANNELS, st.chans);
        write_reg(REG_KERNEL_SIZE, st.kernel);
        write_reg(REG_STRIDE, st.stride);
        settings_run++;
        @(negedge clk);
    endtask

    task automatic set_flow(input flow_t mode);
        case (mode)
            FLOW_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SEND_IDLE:  begin send_idle_pct = 71; recv_stall_pct = 0;  end
            FLOW_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default:         begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    task automatic push_pixel(input pixel_t px);
        pixel_queue.push_back(px);
        pixels_queued++;
    endtask

    task automatic queue_random(input int n);
        repeat (n)
            push_pixel(random_pixel());
    endtask

    // Hold off the sender until every word is taken and every pooled word has come back
    task automatic drain_block();
        while (pixels_taken != pixels_queued || expected_pools.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: offer queued pixels, hold each until taken
    always @(posedge clk)
    begin
        if (!rst_n)
            pixel_valid <= 1'b0;
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                pool_pixel(pixel_value);
                pixels_taken++;
            end
            if (!pixel_valid || pixel_ready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_value <= pixel_queue.pop_front();
                    pixel_valid <= 1'b1;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: compare each pooled word with the oldest expectation
    always @(posedge clk)
    begin : pool_monitor
        pool_word_t want;
        if (rst_n && pooled_valid && pooled_ready)
        begin
            results_seen++;
            if (frame_last === 1'b1)
                frame_ends_seen++;
            if (expected_pools.size() == 0)
            begin
                $display("%0t: unexpected pooled word %0d last %b",
                         $time, pooled_value, frame_last);
                fail_count++;
            end
            else
            begin
                want = expected_pools.pop_front();
                if (pooled_value !== want.pooled)
                begin
                    $display("%0t: pooled_value expected %0d actual %0d",
                             $time, want.pooled, pooled_value);
                    fail_count++;
                end
                if (frame_last !== want.last)
                begin
                    $display("%0t: frame_last expected %b actual %b",
                             $time, want.last, frame_last);
                    fail_count++;
                end
            end
        end
        pooled_ready <= (hold_arm || hold_left != 0) ? 1'b0
                      : ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pooled words outstanding",
                     cycle_count, expected_pools.size());
            $display("[max_pooling_2d] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        pool_setting_t st;
        int n, phase, frame_len;

        // predictor reset state
        cfg_height   = RST_IN_HEIGHT;
        cfg_width    = RST_IN_WIDTH;
        cfg_channels = RST_CHANNELS;
        cfg_kernel   = RST_KERNEL_SIZE;
        cfg_stride   = RST_STRIDE;
        foreach (pool_store[i])
            pool_store[i] = '0;
        restart_frame();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: extreme values first, then the rest of the frame
        set_flow(FLOW_FREE);
        for (n = 0; n < 16; n++)
            push_pixel(pixel_t'(EDGE_PIXELS[255 - 16 * n -: 16]));
        queue_random(48);
        drain_block();

        // unit kernel: every pixel gives a word; the receiver holds off meanwhile
        apply_setting('{4, 4, 3, 1, 1});
        hold_arm = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
        queue_random(48);
        drain_block();

        // odd sizes, stride below kernel; pause mid-frame until all words are back
        apply_setting('{5, 7, 2, 3, 2});
        set_flow(FLOW_RECV_STALL);
        queue_random(35);
        drain_block();
        queue_random(35);
        drain_block();

        // largest kernel at unit stride
        apply_setting('{6, 6, 2, 4, 1});
        set_flow(FLOW_BOTH);
        queue_random(72);
        drain_block();

        // kernel wider than the map: nothing comes out
        apply_setting('{2, 2, 1, 4, 3});
        set_flow(FLOW_FREE);
        queue_random(10);
        drain_block();

        // zero and overlarge register values get clamped
        apply_setting('{0, 127, 0, 0, 7});
        set_flow(FLOW_SEND_IDLE);
        queue_random(40);
        drain_block();

        // partial frame, cut short by the next write
        apply_setting('{127, 5, 511, 5, 0});
        set_flow(FLOW_RECV_STALL);
        queue_random(30);
        drain_block();

        // single-pixel frames
        apply_setting('{1, 1, 1, 1, 1});
        set_flow(FLOW_FREE);
        queue_random(10);
        drain_block();

        // widest row, most channels, largest stride
        apply_setting('{4, 64, 256, 4, 4});
        set_flow(FLOW_BOTH);
        queue_random(256);
        drain_block();

        // random settings, mostly windows that fit, run over whole frames where short
        phase = 0;
        while (phase < 4 || pixels_queued < RANDOM_WORDS)
        begin
            st.height = $urandom_range(1, 8);
            st.width  = $urandom_range(1, 10);
            st.chans  = $urandom_range(1, 3);
            st.kernel = $urandom_range(1, 4);
            st.stride = $urandom_range(1, 4);
            if ($urandom_range(9) < 8)
            begin
                if (st.kernel > st.height)
                    st.kernel = st.height;
                if (st.kernel > st.width)
                    st.kernel = st.width;
            end
            else
            begin
                st.height = $urandom_range(0, 127);
                st.chans  = $urandom_range(0, 511);
                st.kernel = $urandom_range(0, 7);
                st.stride = $urandom_range(0, 7);
            end
            frame_len = clamp_to(st.height, 1, MAX_H) * clamp_to(st.width, 1, MAX_W)
                        * clamp_to(st.chans, 1, MAX_CH);
            n = (frame_len <= 24) ? frame_len : $urandom_range(8, 24);
            apply_setting(st);
            set_flow(flow_t'(phase % 4));
            queue_random(n);
            drain_block();
            phase++;
        end

        $display("Fed %0d pixel words under %0d register settings with idle and stall phases.",
                 pixels_queued, settings_run);
        $display("Compared %0d pooled words, %0d of them frame ends.",
                 results_seen, frame_ends_seen);
        if (fail_count == 0)
            $display("[max_pooling_2d] OK");
        else
            $display("[max_pooling_2d] ERROR");
        $finish;
    end

endmodule
